/* rtl/hashed_pixel_noise_shader_top_assert.svh */
// assertion macros for the hashed pixel noise shader checker
// no dependencies; included by the checker file
`ifndef HASHED_PIXEL_NOISE_SHADER_TOP_ASSERT_SVH
`define HASHED_PIXEL_NOISE_SHADER_TOP_ASSERT_SVH

// same-cycle implication
`define HPNS_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("hpns assertion failed");

// implication with a fixed delay in cycles
`define HPNS_ASSERT_DLY(lbl, clk, rstn, ante, n, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> ##n (cons)) \
    else $error("hpns delayed assertion failed");

`endif

/* rtl/hpns_pkg.sv */
// shared types and constants of the hashed pixel noise shader
// no dependencies
`default_nettype none

package hpns_pkg;

  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [31:0] HASH_K_COL   = 32'd73856093;
  localparam logic [31:0] HASH_K_ROW   = 32'd19349663;
  localparam logic [31:0] HASH_K_FRAME = 32'd83492791;
  localparam logic [31:0] HASH_XOR     = 32'd61;
  localparam logic [31:0] HASH_MUL     = 32'h27d4eb2d;
  // x / 255 == (x * RECIP_255) >> RECIP_SHIFT for any 16-bit x
  localparam logic [15:0] RECIP_255    = 16'h8081;
  localparam int unsigned RECIP_SHIFT  = 23;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_GRAY      = 3'd0,
    CFG_SWING_AMP      = 3'd1,
    CFG_GRAY_BIAS      = 3'd2,
    CFG_KICK_DENSITY   = 3'd3,
    CFG_PULSE_STRENGTH = 3'd4,
    CFG_FRAME_COUNT    = 3'd5,
    CFG_ORIGIN_X       = 3'd6,
    CFG_ORIGIN_Y       = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] col_offset;
    logic [5:0] row_offset;
    logic       pixel_lit;
  } pix_in_t;

  typedef struct packed {
    logic [8:0] screen_x;
    logic [6:0] screen_y;
    logic [3:0] gray_level;
  } pix_out_t;

  typedef struct packed {
    logic [7:0] col_offset;
    logic [5:0] row_offset;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic [3:0]  base_gray;
    logic [3:0]  swing_amp;
    logic [4:0]  gray_bias;    // two's complement
    logic [7:0]  kick_density;
    logic [7:0]  origin_x;
    logic [5:0]  origin_y;
    logic [31:0] frame_mul;    // frame_count * HASH_K_FRAME
    logic [3:0]  pulse_term;   // two's complement, -7..7
  } back_cfg_t;

endpackage

`default_nettype wire

/* rtl/hashed_pixel_noise_shader_top.sv */
// top level of the hashed pixel noise shader: configuration registers,
// frame-derived terms, front end, queue and back end
// depends on hpns_pkg, hpns_front, hpns_queue, hpns_back
//
// Usage:
//   Pixels enter on start / pix_i and are taken at an edge where start is
//   high and busy is low. Unlit pixels and pixels outside the bitmap
//   bounds are dropped in the front end and give no result.
//   A lit pixel that is taken shows on res_o with res_strobe_o high for
//   a single cycle, once it has passed the queue and the back end.
//   One pixel per clock is sustained; the depth is set by the queue, the
//   hash pipeline, the two-stage remainder unit and the result register.
//   The receiver cannot stall, so the back end never holds and busy
//   stays low in normal use.
//   Registers are written through cfg_we_i / cfg_idx_i / cfg_wdata_i while
//   no pixel is in flight; frame-derived terms settle after a write in
//   their registers, and pixels may start the cycle after the last write.
//   Reset clears the config registers to zero and empties the pipeline.
`default_nettype none

module hashed_pixel_noise_shader_top #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 64
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire hpns_pkg::pix_in_t                   pix_i,
  input  wire logic                                cfg_we_i,
  input  wire logic [hpns_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [hpns_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  output logic                                     res_strobe_o,
  output hpns_pkg::pix_out_t                       res_o
);
  import hpns_pkg::*;

  logic [3:0]  base_gray_q;
  logic [3:0]  swing_amp_q;
  logic [4:0]  gray_bias_q;
  logic [7:0]  kick_density_q;
  logic [7:0]  pulse_strength_q;
  logic [31:0] frame_count_q;
  logic [7:0]  origin_x_q;
  logic [5:0]  origin_y_q;

  logic [31:0] frame_mul_q;
  logic [15:0] pulse_prod_q;
  logic        pulse_neg1_q, pulse_neg2_q;
  logic [7:0]  pulse_quot_q;
  logic [3:0]  pulse_term_q;

  logic [6:0]  tri_v;
  logic [7:0]  tri_mag;
  logic        tri_neg;
  logic [31:0] quot_full;
  logic [11:0] pulse_scaled;
  logic [3:0]  pulse_mag;

  q_entry_t  push_data, head;
  q_status_t q_status;
  logic      push;
  back_cfg_t back_cfg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_gray_q      <= '0;
      swing_amp_q      <= '0;
      gray_bias_q      <= '0;
      kick_density_q   <= '0;
      pulse_strength_q <= '0;
      frame_count_q    <= '0;
      origin_x_q       <= '0;
      origin_y_q       <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_BASE_GRAY:      base_gray_q      <= cfg_wdata_i[3:0];
        CFG_SWING_AMP:      swing_amp_q      <= cfg_wdata_i[3:0];
        CFG_GRAY_BIAS:      gray_bias_q      <= cfg_wdata_i[4:0];
        CFG_KICK_DENSITY:   kick_density_q   <= cfg_wdata_i[7:0];
        CFG_PULSE_STRENGTH: pulse_strength_q <= cfg_wdata_i[7:0];
        CFG_FRAME_COUNT:    frame_count_q    <= cfg_wdata_i[31:0];
        CFG_ORIGIN_X:       origin_x_q       <= cfg_wdata_i[7:0];
        CFG_ORIGIN_Y:       origin_y_q       <= cfg_wdata_i[5:0];
        default: ;
      endcase
    end
  end

  // triangle of the low frame byte: tri = 2*v - 128, kept as sign and magnitude
  always_comb begin
    tri_v        = frame_count_q[7] ? ~frame_count_q[6:0] : frame_count_q[6:0];
    tri_neg      = !tri_v[6];
    tri_mag      = tri_neg ? (8'd128 - {tri_v, 1'b0}) : ({tri_v, 1'b0} - 8'd128);
    quot_full    = {16'd0, pulse_prod_q} * {16'd0, RECIP_255};
    pulse_scaled = {4'd0, pulse_quot_q} * {8'd0, swing_amp_q};
    // (q * amp) / 2 / 128 on the magnitude
    pulse_mag    = pulse_scaled[11:8];
  end

  always_ff @(posedge clk_i) begin
    frame_mul_q  <= frame_count_q * HASH_K_FRAME;
    pulse_prod_q <= {8'd0, tri_mag} * {8'd0, pulse_strength_q};
    pulse_neg1_q <= tri_neg;
    pulse_quot_q <= quot_full[RECIP_SHIFT+7:RECIP_SHIFT];
    pulse_neg2_q <= pulse_neg1_q;
    pulse_term_q <= pulse_neg2_q ? (4'd0 - pulse_mag) : pulse_mag;
  end

  always_comb begin
    back_cfg.base_gray    = base_gray_q;
    back_cfg.swing_amp    = swing_amp_q;
    back_cfg.gray_bias    = gray_bias_q;
    back_cfg.kick_density = kick_density_q;
    back_cfg.origin_x     = origin_x_q;
    back_cfg.origin_y     = origin_y_q;
    back_cfg.frame_mul    = frame_mul_q;
    back_cfg.pulse_term   = pulse_term_q;
  end

  hpns_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .start       (start),
    .busy        (busy),
    .pix_i       (pix_i),
    .q_status_i  (q_status),
    .push_o      (push),
    .push_data_o (push_data)
  );

  hpns_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (!q_status.empty),
    .head_o      (head),
    .status_o    (q_status)
  );

  hpns_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (!q_status.empty),
    .entry_i      (head),
    .cfg_i        (back_cfg),
    .res_strobe_o (res_strobe_o),
    .res_o        (res_o)
  );

endmodule

`default_nettype wire

/* rtl/hpns_front.sv */
// front end: takes pixels, drops unlit and out-of-bitmap ones, pushes the rest
// depends on hpns_pkg
`default_nettype none

module hpns_front #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 64
) (
  input  wire logic               start,
  output logic                    busy,
  input  wire hpns_pkg::pix_in_t  pix_i,
  input  wire hpns_pkg::q_status_t q_status_i,
  output logic                    push_o,
  output hpns_pkg::q_entry_t      push_data_o
);
  import hpns_pkg::*;

  logic in_bounds;

  assign in_bounds = ({1'b0, pix_i.col_offset} < 9'(MAX_WIDTH)) &&
                     ({1'b0, pix_i.row_offset} < 7'(MAX_HEIGHT));

  assign busy   = q_status_i.full;
  assign push_o = start && !q_status_i.full && pix_i.pixel_lit && in_bounds;

  assign push_data_o.col_offset = pix_i.col_offset;
  assign push_data_o.row_offset = pix_i.row_offset;

endmodule

`default_nettype wire

/* rtl/hpns_queue.sv */
// short queue between front and back end
// depends on hpns_pkg
`default_nettype none

module hpns_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire hpns_pkg::q_entry_t  push_data_i,
  input  wire logic                pop_i,
  output hpns_pkg::q_entry_t       head_o,
  output hpns_pkg::q_status_t      status_o
);
  import hpns_pkg::*;

  q_entry_t          mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   count_q, count_d;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + (QPTR_W+1)'(push_i) - (QPTR_W+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign head_o         = mem_q[rd_ptr_q];
  assign status_o.full  = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign status_o.empty = (count_q == '0);

endmodule

`default_nettype wire

/* rtl/hpns_back.sv */
// back end: hash pipeline, remainder unit, sum and clamp, result register
// depends on hpns_pkg
`default_nettype none

module hpns_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire hpns_pkg::q_entry_t  entry_i,
  input  wire hpns_pkg::back_cfg_t cfg_i,
  output logic                     res_strobe_o,
  output hpns_pkg::pix_out_t       res_o
);
  import hpns_pkg::*;

  // eight restoring steps of a remainder by a small divisor
  function automatic logic [4:0] rem_steps(input logic [4:0] rem_in,
                                           input logic [7:0] bits,
                                           input logic [4:0] divisor);
    logic [5:0] t;
    logic [4:0] r;
    r = rem_in;
    for (int i = 7; i >= 0; i--) begin
      t = {r, bits[i]};
      if (t >= {1'b0, divisor}) begin
        t = t - {1'b0, divisor};
      end
      r = t[4:0];
    end
    return r;
  endfunction

  logic [5:0]  vld_q;
  logic        strobe_q;

  logic [8:0]  sx_q [6];
  logic [6:0]  sy_q [6];

  logic [31:0] s1_x_q, s2_x_q, s3_x_q;
  logic [15:0] s4_mag_q;
  logic        s4_sgn_q, s4_kick_q;
  logic [4:0]  s5_rem_q;
  logic [7:0]  s5_low_q;
  logic        s5_sgn_q, s5_kick_q;
  logic [4:0]  s6_rem_q;
  logic        s6_sgn_q, s6_kick_q;
  pix_out_t    res_q;

  logic [31:0] x0, x1, x2, x3, x4, h;
  logic [4:0]  divisor;
  logic [4:0]  kick_val;
  logic [7:0]  base8, bias8, pulse8, rnd8, kick8, sum8;
  logic [3:0]  gray;

  always_comb begin
    x0 = ({24'd0, entry_i.col_offset} * HASH_K_COL) ^
         ({26'd0, entry_i.row_offset} * HASH_K_ROW) ^ cfg_i.frame_mul;
    x1 = (s1_x_q ^ HASH_XOR) ^ (s1_x_q >> 16);
    x2 = x1 + (x1 << 3);
    x3 = x2 ^ (x2 >> 4);
    x4 = s2_x_q * HASH_MUL;
    h  = s3_x_q ^ (s3_x_q >> 15);
  end

  assign divisor  = {1'b0, cfg_i.swing_amp} + 5'd1;
  assign kick_val = 5'(({2'b00, cfg_i.swing_amp} * 6'd3) >> 1);

  always_comb begin
    base8  = {4'd0, cfg_i.base_gray};
    bias8  = {{3{cfg_i.gray_bias[4]}}, cfg_i.gray_bias};
    pulse8 = {{4{cfg_i.pulse_term[3]}}, cfg_i.pulse_term};
    rnd8   = s6_sgn_q ? (8'd0 - {3'd0, s6_rem_q}) : {3'd0, s6_rem_q};
    kick8  = s6_kick_q ? {3'd0, kick_val} : 8'd0;
    sum8   = base8 + bias8 + pulse8 + rnd8 - kick8;
    priority if (sum8[7]) begin
      gray = 4'd0;
    end else if (sum8[6:4] != 3'd0) begin
      gray = 4'd15;
    end else begin
      gray = sum8[3:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      vld_q    <= {vld_q[4:0], in_valid_i};
      strobe_q <= vld_q[5];
    end
  end

  always_ff @(posedge clk_i) begin
    sx_q[0] <= {1'b0, cfg_i.origin_x} + {1'b0, entry_i.col_offset};
    sy_q[0] <= {1'b0, cfg_i.origin_y} + {1'b0, entry_i.row_offset};
    for (int i = 1; i < 6; i++) begin
      sx_q[i] <= sx_q[i-1];
      sy_q[i] <= sy_q[i-1];
    end
    s1_x_q    <= x0;
    s2_x_q    <= x3;
    s3_x_q    <= x4;
    s4_mag_q  <= h[23:8];
    s4_sgn_q  <= h[24];
    s4_kick_q <= (h[7:0] < cfg_i.kick_density);
    // remainder of the 16-bit magnitude, high byte then low byte
    s5_rem_q  <= rem_steps(5'd0, s4_mag_q[15:8], divisor);
    s5_low_q  <= s4_mag_q[7:0];
    s5_sgn_q  <= s4_sgn_q;
    s5_kick_q <= s4_kick_q;
    s6_rem_q  <= rem_steps(s5_rem_q, s5_low_q, divisor);
    s6_sgn_q  <= s5_sgn_q;
    s6_kick_q <= s5_kick_q;
    res_q.screen_x   <= sx_q[5];
    res_q.screen_y   <= sy_q[5];
    res_q.gray_level <= gray;
  end

  assign res_strobe_o = strobe_q;
  assign res_o        = res_q;

endmodule

`default_nettype wire

/* rtl/hpns_checker.sv */
// port-level checker for the hashed pixel noise shader, bound to the top level
// depends on hpns_pkg and hashed_pixel_noise_shader_top_assert.svh
`default_nettype none
`include "hashed_pixel_noise_shader_top_assert.svh"

module hpns_checker #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  input  wire logic               busy,
  input  wire hpns_pkg::pix_in_t  pix_i,
  input  wire logic               res_strobe_o,
  input  wire hpns_pkg::pix_out_t res_o
);
  import hpns_pkg::*;

  logic in_bounds;
  logic take_pix;

  assign in_bounds = ({1'b0, pix_i.col_offset} < 9'(MAX_WIDTH)) &&
                     ({1'b0, pix_i.row_offset} < 7'(MAX_HEIGHT));
  assign take_pix  = start && !busy && pix_i.pixel_lit && in_bounds;

  // every drawn pixel gives exactly one result
  `HPNS_ASSERT_DLY(a_lit_gives_result, clk_i, rst_ni, take_pix, 8, res_strobe_o)
  `HPNS_ASSERT_DLY(a_no_invented_result, clk_i, rst_ni, !take_pix, 8, !res_strobe_o)
  // screen coordinates never fall below the offsets of the matching pixel
  `HPNS_ASSERT_IMPL(a_screen_x_order, clk_i, rst_ni, res_strobe_o, res_o.screen_x >= {1'b0, $past(pix_i.col_offset, 8)})
  `HPNS_ASSERT_IMPL(a_screen_y_order, clk_i, rst_ni, res_strobe_o, res_o.screen_y >= {1'b0, $past(pix_i.row_offset, 8)})

endmodule

bind hashed_pixel_noise_shader_top hpns_checker #(
  .MAX_WIDTH  (MAX_WIDTH),
  .MAX_HEIGHT (MAX_HEIGHT)
) u_hpns_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .pix_i        (pix_i),
  .res_strobe_o (res_strobe_o),
  .res_o        (res_o)
);

`default_nettype wire
